// ----- rtl/core/bse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bse_pkg;

  localparam int PACK_W       = 17;
  localparam int CELLS_W      = 6;
  localparam int LEVEL_W      = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;

  localparam int DIV_WORD_W   = 18;
  localparam int DIV_STAGES   = 6;
  localparam int DIV_STEPS    = 3;

  localparam int SEG_COUNT    = 10;
  localparam int SEG_W        = 4;
  localparam int MV_W         = 13;
  localparam int DIFF_W       = 10;
  localparam int PROD_W       = 17;
  localparam int REM_W        = 18;
  localparam int QUO_W        = 8;
  localparam int QUO_STAGES   = 4;
  localparam int QUO_STEPS    = 2;
  localparam int SUM_W        = 11;

  localparam logic [LEVEL_W-1:0]   FULL_TENTHS      = 10'd1000;
  localparam logic [6:0]           STEP_TENTHS      = 7'd100;
  localparam logic [CELLS_W-1:0]   CELL_COUNT_RESET = 6'd24;
  localparam logic [LEVEL_W-1:0]   CUTOFF_RESET     = 10'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_LEVEL = 2'd1;

  typedef struct packed {
    logic [CELLS_W-1:0]    rem;
    logic [DIV_WORD_W-1:0] word;
  } div_state_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } quo_state_t;

  function automatic logic [MV_W-1:0] bound_mv(input logic [SEG_W-1:0] idx);
    logic [MV_W-1:0] mv;
    case (idx)
      4'd0:    mv = 13'd2540;
      4'd1:    mv = 13'd3250;
      4'd2:    mv = 13'd3340;
      4'd3:    mv = 13'd3430;
      4'd4:    mv = 13'd3550;
      4'd5:    mv = 13'd3650;
      4'd6:    mv = 13'd3740;
      4'd7:    mv = 13'd3820;
      4'd8:    mv = 13'd3890;
      4'd9:    mv = 13'd3950;
      default: mv = 13'd4150;
    endcase
    return mv;
  endfunction

  function automatic logic [DIFF_W-1:0] span_mv(input logic [SEG_W-1:0] seg);
    logic [MV_W-1:0] sp;
    sp = bound_mv(SEG_W'(seg + 4'd1)) - bound_mv(seg);
    return sp[DIFF_W-1:0];
  endfunction

  function automatic div_state_t div_step(input div_state_t s, input logic [CELLS_W-1:0] d);
    logic [CELLS_W:0] r;
    div_state_t       o;
    r      = {s.rem, s.word[DIV_WORD_W-1]};
    o.word = {s.word[DIV_WORD_W-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      r         = r - {1'b0, d};
      o.word[0] = 1'b1;
    end
    o.rem = r[CELLS_W-1:0];
    return o;
  endfunction

  function automatic quo_state_t quo_step(input quo_state_t s, input logic [DIFF_W-1:0] span,
                                          input int sh);
    logic [REM_W-1:0] m;
    quo_state_t       o;
    m = REM_W'(span) << sh;
    o = s;
    if (s.rem >= m) begin
      o.rem = s.rem - m;
      o.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/battery_soc_estimator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Battery state-of-charge estimator.
// Input channel: pack_voltage_mv_i with in_valid_i / in_stall_o; a transaction
// completes on a rising edge with valid high and stall low.
// Output channel: charge_tenths_o and below_cutoff_o with out_valid_o / out_stall_i.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0: cell count, 1: cutoff level); other indexes are ignored.
// A cell count of zero divides as one.
// Pipeline: a six-stage restoring divider (three quotient bits per stage)
// followed by a seven-stage segment, multiply, quotient and clamp pipeline.
// Throughput: one transaction per cycle while the output is not stalled;
// every stage holds a valid bit.
// Stall: a stalled output holds its result; earlier stages keep filling
// bubbles and in_stall_o rises only once all stages are full.
// Reset: clears every valid bit and loads cell count 24 and cutoff 100.

module battery_soc_estimator import bse_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PACK_W-1:0]     pack_voltage_mv_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [LEVEL_W-1:0]         charge_tenths_o,
  output logic                       below_cutoff_o
);

  logic [CELLS_W-1:0] cell_count_q;
  logic [LEVEL_W-1:0] cutoff_level_q;
  logic [CELLS_W-1:0] divisor;
  logic               mid_valid, mid_stall;
  logic [PACK_W-1:0]  cell_mv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q   <= CELL_COUNT_RESET;
      cutoff_level_q <= CUTOFF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CELL_COUNT:   cell_count_q   <= cfg_data_i[CELLS_W-1:0];
        CFG_CUTOFF_LEVEL: cutoff_level_q <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign divisor = (cell_count_q == '0) ? CELLS_W'(1) : cell_count_q;

  bse_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pack_mv_i   (pack_voltage_mv_i),
    .divisor_i   (divisor),
    .out_valid_o (mid_valid),
    .out_stall_i (mid_stall),
    .cell_mv_o   (cell_mv)
  );

  bse_interp u_interp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (mid_valid),
    .in_stall_o      (mid_stall),
    .cell_mv_i       (cell_mv),
    .cutoff_level_i  (cutoff_level_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .charge_tenths_o (charge_tenths_o),
    .below_cutoff_o  (below_cutoff_o)
  );

`ifndef NO_ASSERTIONS
  a_charge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> charge_tenths_o <= FULL_TENTHS)
    else $error("charge out of range");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/bse_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bse_div import bse_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [PACK_W-1:0]  pack_mv_i,
  input  wire logic [CELLS_W-1:0] divisor_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [PACK_W-1:0]       cell_mv_o
);

  logic [DIV_STAGES-1:0] valid_q;
  logic [DIV_STAGES:0]   ready;
  div_state_t            st_q [DIV_STAGES];
  div_state_t            st_d [DIV_STAGES];
  div_state_t            st_in [DIV_STAGES];

  always_comb begin
    ready[DIV_STAGES] = !out_stall_i;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    st_in[0].rem  = '0;
    st_in[0].word = {1'b0, pack_mv_i};
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_in[k] = st_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      st_d[k] = st_in[k];
      for (int t = 0; t < DIV_STEPS; t++) begin
        st_d[k] = div_step(st_d[k], divisor_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (ready[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[DIV_STAGES-1];
  assign cell_mv_o   = st_q[DIV_STAGES-1].word[PACK_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/bse_interp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bse_interp import bse_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [PACK_W-1:0]  cell_mv_i,
  input  wire logic [LEVEL_W-1:0] cutoff_level_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [LEVEL_W-1:0]      charge_tenths_o,
  output logic                    below_cutoff_o
);

  localparam int N_ST = 3 + QUO_STAGES;

  logic [N_ST-1:0]    valid_q;
  logic [N_ST:0]      ready;

  logic [SEG_W-1:0]   seg_q [N_ST-1];
  logic [SEG_W-1:0]   seg_d;
  logic [DIFF_W-1:0]  diff_q, diff_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  quo_state_t         q_q [QUO_STAGES];
  quo_state_t         q_d [QUO_STAGES];
  logic [LEVEL_W-1:0] charge_q, charge_d;
  logic               below_q, below_d;

  logic [MV_W-1:0]    hi_mv, lo_mv, v_mv;
  logic [PACK_W-1:0]  hi_ext;
  logic               low;
  logic [SUM_W-1:0]   sum;

  always_comb begin
    ready[N_ST] = !out_stall_i;
    for (int k = N_ST - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    low   = !(cell_mv_i > PACK_W'(bound_mv(SEG_W'(0))));
    seg_d = '0;
    for (int j = 1; j < SEG_COUNT; j++) begin
      if (cell_mv_i > PACK_W'(bound_mv(SEG_W'(j)))) begin
        seg_d = SEG_W'(j);
      end
    end
    hi_mv  = bound_mv(SEG_W'(seg_d + 4'd1));
    lo_mv  = bound_mv(seg_d);
    hi_ext = PACK_W'(hi_mv);
    v_mv   = (cell_mv_i > hi_ext) ? hi_mv : cell_mv_i[MV_W-1:0];
    diff_d = low ? '0 : DIFF_W'(v_mv - lo_mv);
  end

  assign prod_d = PROD_W'(diff_q) * PROD_W'(STEP_TENTHS);

  always_comb begin
    for (int j = 0; j < QUO_STAGES; j++) begin
      if (j == 0) begin
        q_d[j].rem = REM_W'(prod_q);
        q_d[j].quo = '0;
      end else begin
        q_d[j] = q_q[j-1];
      end
      for (int t = 0; t < QUO_STEPS; t++) begin
        q_d[j] = quo_step(q_d[j], span_mv(seg_q[1+j]), QUO_W - 1 - (j * QUO_STEPS + t));
      end
    end
  end

  always_comb begin
    sum = SUM_W'(q_q[QUO_STAGES-1].quo)
        + SUM_W'(seg_q[N_ST-2]) * SUM_W'(STEP_TENTHS);
    charge_d = (sum > SUM_W'(FULL_TENTHS)) ? FULL_TENTHS : sum[LEVEL_W-1:0];
    below_d  = charge_d < cutoff_level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N_ST; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      seg_q[0] <= seg_d;
      diff_q   <= diff_d;
    end
    if (ready[1]) begin
      seg_q[1] <= seg_q[0];
      prod_q   <= prod_d;
    end
    for (int j = 0; j < QUO_STAGES; j++) begin
      if (ready[2+j]) begin
        seg_q[2+j] <= seg_q[1+j];
        q_q[j]     <= q_d[j];
      end
    end
    if (ready[N_ST-1]) begin
      charge_q <= charge_d;
      below_q  <= below_d;
    end
  end

  assign in_stall_o      = !ready[0];
  assign out_valid_o     = valid_q[N_ST-1];
  assign charge_tenths_o = charge_q;
  assign below_cutoff_o  = below_q;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

import bse_pkg::*;

typedef struct packed {
  logic [LEVEL_W-1:0] charge;
  logic               low;
} soc_result_t;

class charge_ledger;
  int unsigned        knee_mv[SEG_COUNT+1];
  logic [CELLS_W-1:0] cells;
  logic [LEVEL_W-1:0] cutoff;
  soc_result_t        charge_due[$];
  int                 fault_count;

  function new();
    knee_mv = '{4150, 3950, 3890, 3820, 3740, 3650, 3550, 3430, 3340, 3250, 2540};
    cells = CELL_COUNT_RESET;
    cutoff = CUTOFF_RESET;
    fault_count = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_CELL_COUNT) begin
      cells = data[CELLS_W-1:0];
    end else if (idx == CFG_CUTOFF_LEVEL) begin
      cutoff = data[LEVEL_W-1:0];
    end
  endfunction

  function soc_result_t estimate_charge(logic [PACK_W-1:0] pack);
    int unsigned divisor, cell_mv, hi, lo, capped, level;
    bit          found;
    soc_result_t res;
    divisor = (cells == 0) ? 1 : cells;
    cell_mv = pack / divisor;
    level = 0;
    found = 1'b0;
    for (int i = 0; i < SEG_COUNT; i++) begin
      hi = knee_mv[i];
      lo = knee_mv[i+1];
      if (!found && cell_mv > lo) begin
        capped = (cell_mv > hi) ? hi : cell_mv;
        level = (capped - lo) * 100 / (hi - lo) + (SEG_COUNT - 1 - i) * 100;
        found = 1'b1;
      end
    end
    if (level > FULL_TENTHS) level = FULL_TENTHS;
    res.charge = level[LEVEL_W-1:0];
    res.low = (level < cutoff);
    return res;
  endfunction

  function void note(logic [PACK_W-1:0] pack);
    charge_due.push_back(estimate_charge(pack));
  endfunction

  function void check(logic [LEVEL_W-1:0] charge, logic low);
    soc_result_t want;
    if (charge_due.size() == 0) begin
      $error("unexpected transaction: charge_tenths %0d below_cutoff %0d", charge, low);
      fault_count++;
      return;
    end
    want = charge_due.pop_front();
    if (charge !== want.charge) begin
      $error("charge_tenths: expected %0d, actual %0d", want.charge, charge);
      fault_count++;
    end
    if (low !== want.low) begin
      $error("below_cutoff: expected %0d, actual %0d", want.low, low);
      fault_count++;
    end
  endfunction

  function int pending();
    return charge_due.size();
  endfunction
endclass

module tb;

  localparam int unsigned PACK_MAX = (1 << PACK_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PACK_W-1:0]     pack_mv;
  logic                  out_valid;
  logic                  out_stall;
  logic [LEVEL_W-1:0]    charge_tenths;
  logic                  below_cutoff;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  charge_ledger sb;

  battery_soc_estimator uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .pack_voltage_mv_i (pack_mv),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .charge_tenths_o   (charge_tenths),
    .below_cutoff_o    (below_cutoff)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check(charge_tenths, below_cutoff);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic set_mode(input int mode);
    case (mode)
      0: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct = 56;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 56;
      end
      default: begin
        idle_pct = 20;
        stall_pct = 20;
      end
    endcase
  endtask

  task automatic send_sample(input logic [PACK_W-1:0] pack);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pack_mv <= pack;
    do @(posedge clk); while (in_stall);
    sb.note(pack);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PACK_W-1:0] random_pack();
    int unsigned eff, mv, p, top;
    eff = (sb.cells == 0) ? 1 : sb.cells;
    top = PACK_MAX / eff;
    case ($urandom_range(7))
      0, 1: p = $urandom_range(PACK_MAX, 0);
      2: begin
        mv = sb.knee_mv[$urandom_range(SEG_COUNT)];
        p = mv * eff + $urandom_range(eff - 1, 0);
      end
      default: begin
        mv = $urandom_range(4300, 2400);
        p = mv * eff + $urandom_range(eff - 1, 0);
      end
    endcase
    if (p > PACK_MAX) p = $urandom_range(top, 0) * eff + $urandom_range(eff - 1, 0);
    if (p > PACK_MAX) p = PACK_MAX;
    return p[PACK_W-1:0];
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_sample(random_pack());
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] cells_data,
                           input logic [CFG_DATA_W-1:0] cutoff_data, input int mode);
    drain();
    write_reg(CFG_CELL_COUNT, cells_data);
    write_reg(CFG_CUTOFF_LEVEL, cutoff_data);
    set_mode(mode);
    run_random(300);
  endtask

  initial begin
    int unsigned pack_probe[7] = '{0, 60960, 60961, 60984, 99600, 99624, 131071};
    int unsigned cell_probe[19] = '{0, 1, 2540, 2541, 2895, 3250, 3251, 3340, 3430, 3550,
                                    3650, 3740, 3820, 3890, 3950, 4000, 4150, 4151, 131071};
    sb = new();
    cfg_we <= 1'b0;
    cfg_index <= CFG_CELL_COUNT;
    cfg_data <= '0;
    in_valid <= 1'b0;
    pack_mv <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mode(0);
    foreach (pack_probe[i]) send_sample(PACK_W'(pack_probe[i]));
    run_random(300);

    drain();
    write_reg(CFG_CELL_COUNT, 10'h001);
    write_reg(CFG_CUTOFF_LEVEL, 10'd0);
    write_reg(2'd2, 10'h3FF);
    set_mode(1);
    foreach (cell_probe[i]) send_sample(PACK_W'(cell_probe[i]));
    run_random(300);

    drain();
    write_reg(2'd3, 10'h155);
    run_phase({4'hF, 6'd32}, 10'd1000, 2);
    run_phase(10'd0, 10'd1023, 3);
    run_phase(10'd63, 10'd500, 0);
    run_phase(CFG_DATA_W'($urandom_range(32, 1)), CFG_DATA_W'($urandom_range(1000)), 1);
    run_phase(CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'($urandom_range(1023)), 2);

    drain();
    repeat (20) @(posedge clk);
    if (sb.fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
